// ===== sv/gravity_tensor_frame_rotation_assert.svh =====
// assertion macros for the tensor rotation block
// expects clk and rst_n in the scope of use
`ifndef GRAVITY_TENSOR_FRAME_ROTATION_ASSERT_SVH
`define GRAVITY_TENSOR_FRAME_ROTATION_ASSERT_SVH

// implication in the same cycle, off during reset
`define GTFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtfr assertion failed");

// implication into the next cycle, reset included
`define GTFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gtfr assertion failed");

`endif

// ===== sv/gtfr_pkg.sv =====
// shared constants, types and helpers for the tensor rotation block
// no dependencies
package gtfr_pkg;

  localparam int DEG_FULL    = 23592960;
  localparam int DEG_HALF    = 11796480;
  localparam int DEG_QUARTER = 5898240;
  localparam logic signed [27:0] RAD_PER_DEG_Q32 = 28'sd74961321;
  localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam int TABLE_LEN = 30;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LONGITUDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LATITUDE  = 2'd1;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [31:0] trig_t;

  // atan(2^-i) with 30 fraction bits
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'h03243F6A8;
      5'd1:  v = 34'h01DAC6705;
      5'd2:  v = 34'h00FADBAFC;
      5'd3:  v = 34'h007F56EA6;
      5'd4:  v = 34'h003FEAB76;
      5'd5:  v = 34'h001FFD55B;
      5'd6:  v = 34'h000FFFAAA;
      5'd7:  v = 34'h0007FFF55;
      5'd8:  v = 34'h0003FFFEA;
      5'd9:  v = 34'h0001FFFFD;
      5'd10: v = 34'h0000FFFFF;
      5'd11: v = 34'h00007FFFF;
      5'd12: v = 34'h00003FFFF;
      5'd13: v = 34'h00001FFFF;
      5'd14: v = 34'h00000FFFF;
      5'd15: v = 34'h000007FFF;
      5'd16: v = 34'h000003FFF;
      5'd17: v = 34'h000001FFF;
      5'd18: v = 34'h000000FFF;
      5'd19: v = 34'h0000007FF;
      5'd20: v = 34'h0000003FF;
      5'd21: v = 34'h0000001FF;
      5'd22: v = 34'h0000000FF;
      5'd23: v = 34'h00000007F;
      5'd24: v = 34'h00000003F;
      5'd25: v = 34'h00000001F;
      5'd26: v = 34'h00000000F;
      5'd27: v = 34'h000000008;
      5'd28: v = 34'h000000004;
      5'd29: v = 34'h000000002;
      default: v = '0;
    endcase
    return v;
  endfunction

  // (a*b + 2^29) floor / 2^30
  function automatic logic signed [35:0] mul30(input logic signed [33:0] a,
                                               input logic signed [31:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b) + 66'sd536870912;
    return p[65:30];
  endfunction

endpackage

// ===== sv/gtfr_if.sv =====
// channel interfaces for the tensor rotation block
// depends on gtfr_pkg
interface gtfr_in_if;
  import gtfr_pkg::*;
  logic valid;
  logic ready;
  logic signed [25:0] point_longitude;
  logic signed [23:0] point_latitude;
  q16_t in_xx, in_xy, in_xz, in_yx, in_yy, in_yz, in_zx, in_zy, in_zz;
  modport source (output valid, point_longitude, point_latitude, in_xx, in_xy, in_xz,
                  in_yx, in_yy, in_yz, in_zx, in_zy, in_zz, input ready);
  modport sink (input valid, point_longitude, point_latitude, in_xx, in_xy, in_xz,
                in_yx, in_yy, in_yz, in_zx, in_zy, in_zz, output ready);
endinterface

interface gtfr_out_if;
  import gtfr_pkg::*;
  logic valid;
  logic ready;
  q16_t out_xx, out_xy, out_xz, out_yx, out_yy, out_yz, out_zx, out_zy, out_zz;
  modport source (output valid, out_xx, out_xy, out_xz, out_yx, out_yy, out_yz,
                  out_zx, out_zy, out_zz, input ready);
  modport sink (input valid, out_xx, out_xy, out_xz, out_yx, out_yy, out_yz,
                out_zx, out_zy, out_zz, output ready);
endinterface

interface gtfr_cfg_if;
  import gtfr_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/gtfr_sincos.sv =====
// pipelined sine and cosine of an angle in degrees (16 fraction bits)
// reduction, radian scaling, one stage per cordic step, clamp; uses gtfr_pkg
module gtfr_sincos #(
  parameter int ITER = 20
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [26:0] angle,
  output gtfr_pkg::trig_t    sin_o,
  output gtfr_pkg::trig_t    cos_o
);
  import gtfr_pkg::*;

  logic signed [28:0] a0, a1, a2, a3;
  logic signed [24:0] r_nxt, r_r;
  logic neg_nxt, neg0_r;
  logic signed [52:0] rad_p;
  logic signed [33:0] x_r [ITER+1];
  logic signed [33:0] y_r [ITER+1];
  logic signed [33:0] z_r [ITER+1];
  logic neg_r [ITER+1];
  trig_t sin_r, cos_r;
  logic signed [28:0] wrk;

  // modulo 360 into [-180, 180), then fold into [-90, 90]
  always_comb begin
    a0 = 29'(angle) + 29'(4 * DEG_FULL);
    a1 = (a0 >= 29'(4 * DEG_FULL)) ? a0 - 29'(4 * DEG_FULL) : a0;
    a2 = (a1 >= 29'(2 * DEG_FULL)) ? a1 - 29'(2 * DEG_FULL) : a1;
    a3 = (a2 >= 29'(DEG_FULL)) ? a2 - 29'(DEG_FULL) : a2;
    wrk = (a3 >= 29'(DEG_HALF)) ? a3 - 29'(DEG_FULL) : a3;
    neg_nxt = 1'b0;
    if (wrk > 29'(DEG_QUARTER)) begin
      wrk = wrk - 29'(DEG_HALF);
      neg_nxt = 1'b1;
    end else if (wrk < -29'(DEG_QUARTER)) begin
      wrk = wrk + 29'(DEG_HALF);
      neg_nxt = 1'b1;
    end
    r_nxt = wrk[24:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_nxt;
      neg0_r <= neg_nxt;
    end
  end

  assign rad_p = 53'(r_r) * 53'(RAD_PER_DEG_Q32) + 53'sd131072;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN_INV;
      y_r[0] <= '0;
      z_r[0] <= 34'(rad_p[52:18]);
      neg_r[0] <= neg0_r;
    end
  end

  for (genvar g = 0; g < ITER; g++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[g] >= 0) begin
          x_r[g+1] <= x_r[g] - (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] + (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] - atan_q30(5'(g));
        end else begin
          x_r[g+1] <= x_r[g] + (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] - (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] + atan_q30(5'(g));
        end
        neg_r[g+1] <= neg_r[g];
      end
    end
  end

  function automatic trig_t fin(input logic signed [33:0] v, input logic n);
    logic signed [33:0] c;
    c = (v > ONE_Q30) ? ONE_Q30 : ((v < -ONE_Q30) ? -ONE_Q30 : v);
    if (n) c = -c;
    return c[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= fin(x_r[ITER], neg_r[ITER]);
      sin_r <= fin(y_r[ITER], neg_r[ITER]);
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ===== sv/gravity_tensor_frame_rotation.sv =====
// Rotates a 3x3 gravity gradient tensor from a source body's frame into the frame of a
// computation point: out = R*T*R^T, Q16.16 saturated. The source longitude and latitude
// come from configuration registers 0 and 1. One transaction is accepted per cycle while the
// output is not stalled; each result passes through the pipelined cordic units (one stage per
// step), then the multiply stages for R and both matrix products. The whole pipeline holds
// when the output register is full and not taken. Depends on gtfr_pkg, gtfr_if and
// gtfr_sincos.
module gravity_tensor_frame_rotation #(
  parameter int TRIG_ITERATIONS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  gtfr_in_if.sink    in_ch,
  gtfr_out_if.source out_ch,
  gtfr_cfg_if.sink   cfg_ch
);
  import gtfr_pkg::*;

  localparam int TRIG_LAT = TRIG_ITERATIONS + 3;
  localparam int DT = TRIG_LAT + 3;
  localparam int DEPTH = TRIG_ITERATIONS + 10;

  logic signed [25:0] src_lon_r;
  logic signed [23:0] src_lat_r;
  logic en;
  logic vld_r [DEPTH];

  logic signed [26:0] beta, plat, slat;
  trig_t sb, cb, sp, cp, spl, cpl;

  q16_t t_r [DT][9];

  // R build stages
  trig_t cbsp_r, cbcp_r, r1_r, r3_r, r4_r, r5_r, r7_r;
  trig_t cpcpl_r, cpspl_r, spcpl_r, spspl_r, cpl_r, spl_r;
  trig_t r0a_r, r2a_r, r6a_r, r8a_r;
  trig_t p2_r [9];
  trig_t cpcpl2_r, cpspl2_r, spcpl2_r, spspl2_r;
  trig_t rm_r [3][9];

  logic signed [32:0] m1_r [9][3];
  logic signed [33:0] tmp_r [9];
  logic signed [34:0] m3_r [9][3];
  q16_t out_r [9];

  // configuration
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_lon_r <= '0;
      src_lat_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_SOURCE_LONGITUDE: src_lon_r <= cfg_ch.data[25:0];
        REG_SOURCE_LATITUDE:  src_lat_r <= cfg_ch.data[23:0];
        default: ;
      endcase
    end
  end

  assign en = !vld_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  assign beta = 27'(src_lon_r) - 27'(in_ch.point_longitude);
  assign plat = 27'(in_ch.point_latitude);
  assign slat = 27'(src_lat_r);

  gtfr_sincos #(.ITER(TRIG_ITERATIONS)) u_beta (
    .clk(clk), .en(en), .angle(beta), .sin_o(sb), .cos_o(cb));
  gtfr_sincos #(.ITER(TRIG_ITERATIONS)) u_phi (
    .clk(clk), .en(en), .angle(plat), .sin_o(sp), .cos_o(cp));
  gtfr_sincos #(.ITER(TRIG_ITERATIONS)) u_phil (
    .clk(clk), .en(en), .angle(slat), .sin_o(spl), .cos_o(cpl));

  // tensor rides alongside the trig and R stages
  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0][0] <= in_ch.in_xx; t_r[0][1] <= in_ch.in_xy; t_r[0][2] <= in_ch.in_xz;
      t_r[0][3] <= in_ch.in_yx; t_r[0][4] <= in_ch.in_yy; t_r[0][5] <= in_ch.in_yz;
      t_r[0][6] <= in_ch.in_zx; t_r[0][7] <= in_ch.in_zy; t_r[0][8] <= in_ch.in_zz;
      for (int i = 1; i < DT; i++) t_r[i] <= t_r[i-1];
    end
  end

  function automatic trig_t m32(input trig_t a, input trig_t b);
    logic signed [35:0] p;
    p = mul30(34'(a), b);
    return p[31:0];
  endfunction

  function automatic trig_t clamp_r(input logic signed [32:0] v);
    logic signed [32:0] c;
    c = (v > 33'(ONE_Q30)) ? 33'(ONE_Q30) : ((v < -33'(ONE_Q30)) ? -33'(ONE_Q30) : v);
    return c[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cbsp_r <= m32(cb, sp);
      cbcp_r <= m32(cb, cp);
      r1_r <= m32(sb, sp);
      r3_r <= -m32(sb, spl);
      r4_r <= cb;
      r5_r <= m32(sb, cpl);
      r7_r <= -m32(sb, cp);
      cpcpl_r <= m32(cp, cpl);
      cpspl_r <= m32(cp, spl);
      spcpl_r <= m32(sp, cpl);
      spspl_r <= m32(sp, spl);
      cpl_r <= cpl;
      spl_r <= spl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0a_r <= m32(cbsp_r, spl_r);
      r2a_r <= m32(cbsp_r, cpl_r);
      r6a_r <= m32(cbcp_r, spl_r);
      r8a_r <= m32(cbcp_r, cpl_r);
      p2_r[1] <= r1_r; p2_r[3] <= r3_r; p2_r[4] <= r4_r;
      p2_r[5] <= r5_r; p2_r[7] <= r7_r;
      p2_r[0] <= '0; p2_r[2] <= '0; p2_r[6] <= '0; p2_r[8] <= '0;
      cpcpl2_r <= cpcpl_r; cpspl2_r <= cpspl_r;
      spcpl2_r <= spcpl_r; spspl2_r <= spspl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rm_r[0][0] <= clamp_r(33'(r0a_r) + 33'(cpcpl2_r));
      rm_r[0][1] <= clamp_r(33'(p2_r[1]));
      rm_r[0][2] <= clamp_r(33'(cpspl2_r) - 33'(r2a_r));
      rm_r[0][3] <= clamp_r(33'(p2_r[3]));
      rm_r[0][4] <= clamp_r(33'(p2_r[4]));
      rm_r[0][5] <= clamp_r(33'(p2_r[5]));
      rm_r[0][6] <= clamp_r(33'(spcpl2_r) - 33'(r6a_r));
      rm_r[0][7] <= clamp_r(33'(p2_r[7]));
      rm_r[0][8] <= clamp_r(33'(r8a_r) + 33'(spspl2_r));
      rm_r[1] <= rm_r[0];
      rm_r[2] <= rm_r[1];
    end
  end

  // R*T products, then sums clamped to +-2^32
  always_ff @(posedge clk) begin
    logic signed [35:0] p;
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++) begin
            p = mul30(34'(rm_r[0][i*3+k]), t_r[DT-1][k*3+j]);
            m1_r[i*3+j][k] <= p[32:0];
          end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [34:0] s;
    if (en) begin
      for (int e = 0; e < 9; e++) begin
        s = 35'(m1_r[e][0]) + 35'(m1_r[e][1]) + 35'(m1_r[e][2]);
        if (s > 35'sd4294967296) s = 35'sd4294967296;
        else if (s < -35'sd4294967296) s = -35'sd4294967296;
        tmp_r[e] <= s[33:0];
      end
    end
  end

  // (R*T)*R^T products, then sums saturated to 32 bits
  always_ff @(posedge clk) begin
    logic signed [35:0] p;
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++) begin
            p = mul30(tmp_r[i*3+k], rm_r[2][j*3+k]);
            m3_r[i*3+j][k] <= p[34:0];
          end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [36:0] s;
    if (en) begin
      for (int e = 0; e < 9; e++) begin
        s = 37'(m3_r[e][0]) + 37'(m3_r[e][1]) + 37'(m3_r[e][2]);
        if (s > 37'sd2147483647) s = 37'sd2147483647;
        else if (s < -37'sd2147483648) s = -37'sd2147483648;
        out_r[e] <= s[31:0];
      end
    end
  end

  assign out_ch.valid = vld_r[DEPTH-1];
  assign out_ch.out_xx = out_r[0];
  assign out_ch.out_xy = out_r[1];
  assign out_ch.out_xz = out_r[2];
  assign out_ch.out_yx = out_r[3];
  assign out_ch.out_yy = out_r[4];
  assign out_ch.out_yz = out_r[5];
  assign out_ch.out_zx = out_r[6];
  assign out_ch.out_zy = out_r[7];
  assign out_ch.out_zz = out_r[8];

endmodule

// ===== sv/gtfr_checker.sv =====
// port-level checks for the tensor rotation block, bound to the top level
// depends on gravity_tensor_frame_rotation_assert.svh
`include "gravity_tensor_frame_rotation_assert.svh"

module gtfr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a result that is not taken stays offered
  `GTFR_ASSERT_IMP(a_out_hold, out_valid && !out_ready, ##1 out_valid)
  // an empty output stage always takes a new transaction
  `GTFR_ASSERT_IMP(a_in_ready_empty, !out_valid, in_ready)
  // with a result waiting, input flow follows the output side
  `GTFR_ASSERT_IMP(a_in_follows_out, out_valid, in_ready == out_ready)
  // nothing comes out right after reset
  `GTFR_ASSERT_NEXT(a_reset_empty, !rst_n, !out_valid)

endmodule

bind gravity_tensor_frame_rotation gtfr_checker u_gtfr_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready)
);
